>>> hw/rtl/lkvc_pkg.sv
// shared types and constants for the lru key/value cache
`default_nettype none

package lkvc_pkg;

   localparam int MAX_ENTRIES_DEF = 16;
   localparam int KEY_WIDTH_DEF   = 32;
   localparam int VALUE_WIDTH_DEF = 32;

   localparam int CAPACITY_WIDTH = 5;
   localparam int READ_WIDTH     = 32;
   localparam logic [CAPACITY_WIDTH-1:0] CAPACITY_RESET = 5'd16;

   typedef enum logic [1:0] {
      CMD_PUT   = 2'd0,
      CMD_GET   = 2'd1,
      CMD_EXIST = 2'd2
   } cmd_type;

   // per-cell control for one accepted item
   typedef struct packed {
      logic shift;   // take key, value and valid from the neighbor toward the front
      logic drop;    // clear valid, cell lies beyond the capacity
   } cell_ctl_type;

endpackage

`default_nettype wire

>>> hw/rtl/lkvc_cell.sv
// one storage cell of the recency-ordered row
`default_nettype none

module lkvc_cell #(
   parameter int KEY_WIDTH   = 32,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  lkvc_pkg::cell_ctl_type   ctl,
   input  logic [KEY_WIDTH-1:0]     query_key,
   input  logic                     up_valid,
   input  logic [KEY_WIDTH-1:0]     up_key,
   input  logic [VALUE_WIDTH-1:0]   up_value,
   output logic                     valid,
   output logic [KEY_WIDTH-1:0]     key,
   output logic [VALUE_WIDTH-1:0]   value,
   output logic                     match
);

   logic                   valid_ff;
   logic                   valid_in;
   logic [KEY_WIDTH-1:0]   key_ff;
   logic [VALUE_WIDTH-1:0] value_ff;

   always_comb begin
      valid_in = (ctl.shift ? up_valid : valid_ff) & ~ctl.drop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload moves one place back along the row
   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         key_ff   <= up_key;
         value_ff <= up_value;
      end
   end

   assign match = valid_ff & (key_ff == query_key);
   assign valid = valid_ff;
   assign key   = key_ff;
   assign value = value_ff;

endmodule

`default_nettype wire

>>> hw/rtl/lru_key_value_cache_core.sv
// top level of the fully associative lru key/value cache
`default_nettype none

// channel   | direction | fields (low bit first)
// ----------+-----------+---------------------------------------------
// req_*     | in        | tuser: cmd; tdata: key, value, zero pad
// rsp_*     | out       | tuser: hit; tdata: read_value
// csr_*     | in        | wr_data: capacity, written when wr_en is high
//
// all cells compare the key at once and the row shifts toward the back at the
// edge that takes the item, the result lands in an output register and shows
// in the cycle after the item is taken
// reset clears all valid bits (empty cache) and sets capacity to 16
// a stalled result holds in the output register, req_tready is low only
// while that register is full and rsp_tready is low

module lru_key_value_cache_core #(
   parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF,
   parameter int KEY_WIDTH   = lkvc_pkg::KEY_WIDTH_DEF,
   parameter int VALUE_WIDTH = lkvc_pkg::VALUE_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,

   input  logic                                               req_tvalid,
   output logic                                               req_tready,
   // key, value, zero pad
   input  logic [((KEY_WIDTH+VALUE_WIDTH+7)/8)*8-1:0]         req_tdata,
   // cmd
   input  logic [1:0]                                         req_tuser,

   output logic                                               rsp_tvalid,
   input  logic                                               rsp_tready,
   // read_value
   output logic [lkvc_pkg::READ_WIDTH-1:0]                    rsp_tdata,
   // hit
   output logic                                               rsp_tuser,

   input  logic                                               csr_wr_en,
   input  logic [lkvc_pkg::CAPACITY_WIDTH-1:0]                csr_wr_data
);

   import lkvc_pkg::*;

   // item fields
   logic                   accept;
   cmd_type                cmd;
   logic [KEY_WIDTH-1:0]   req_key;
   logic [VALUE_WIDTH-1:0] req_value;

   // decoded command
   logic is_put;
   logic is_get;
   logic is_exist;

   // row of cells
   logic [MAX_ENTRIES-1:0]   valid_vec;
   logic [MAX_ENTRIES-1:0]   match_vec;
   logic [KEY_WIDTH-1:0]     key_vec   [MAX_ENTRIES];
   logic [VALUE_WIDTH-1:0]   value_vec [MAX_ENTRIES];
   cell_ctl_type             ctl_vec   [MAX_ENTRIES];

   logic                   found;
   logic [VALUE_WIDTH-1:0] sel_value;
   logic [VALUE_WIDTH-1:0] head_value;

   // capacity register
   logic [CAPACITY_WIDTH-1:0] csr_capacity_ff;

   // result register
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  rsp_hit_ff;
   logic                  rsp_hit_in;
   logic [READ_WIDTH-1:0] rsp_data_ff;
   logic [READ_WIDTH-1:0] rsp_data_in;

   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign accept     = req_tvalid & req_tready;
   assign cmd        = cmd_type'(req_tuser);
   assign req_key    = req_tdata[KEY_WIDTH-1:0];
   assign req_value  = req_tdata[KEY_WIDTH +: VALUE_WIDTH];

   always_comb begin
      is_put   = 1'b0;
      is_get   = 1'b0;
      is_exist = 1'b0;
      unique case (cmd)
         CMD_PUT:   is_put   = 1'b1;
         CMD_GET:   is_get   = 1'b1;
         CMD_EXIST: is_exist = 1'b1;
         default:   ;   // unused code, no operation
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_capacity_ff <= CAPACITY_RESET;
      end else if (csr_wr_en) begin
         csr_capacity_ff <= csr_wr_data;
      end
   end

   // keys are unique among valid cells, so the match vector is one-hot or empty
   assign found = |match_vec;

   always_comb begin
      sel_value = '0;
      for (int j = 0; j < MAX_ENTRIES; j++) begin
         sel_value = sel_value | (value_vec[j] & {VALUE_WIDTH{match_vec[j]}});
      end
   end

   // front cell takes the new pair on put, the hit entry on get
   assign head_value = is_put ? req_value : sel_value;

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      logic                   up_valid;
      logic [KEY_WIDTH-1:0]   up_key;
      logic [VALUE_WIDTH-1:0] up_value;
      logic                   at_or_before_hit;
      logic                   shift_miss;

      // cells from the front through the hit position shift back
      assign at_or_before_hit = |match_vec[MAX_ENTRIES-1:i];

      if (i == 0) begin : g_head
         assign up_valid   = 1'b1;
         assign up_key     = req_key;
         assign up_value   = head_value;
         assign shift_miss = 1'b1;
      end else begin : g_body
         assign up_valid   = valid_vec[i-1];
         assign up_key     = key_vec[i-1];
         assign up_value   = value_vec[i-1];
         // a new key pushes every live entry back, the last one falls off
         assign shift_miss = valid_vec[i-1];
      end

      assign ctl_vec[i].shift = accept & (((is_put | is_get) & at_or_before_hit)
                                          | (is_put & ~found & shift_miss));
      // trim to capacity after every put
      assign ctl_vec[i].drop  = accept & is_put & (32'(csr_capacity_ff) <= i);

      lkvc_cell #(
         .KEY_WIDTH   (KEY_WIDTH),
         .VALUE_WIDTH (VALUE_WIDTH)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl_vec[i]),
         .query_key (req_key),
         .up_valid  (up_valid),
         .up_key    (up_key),
         .up_value  (up_value),
         .valid     (valid_vec[i]),
         .key       (key_vec[i]),
         .value     (value_vec[i]),
         .match     (match_vec[i])
      );
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = (is_put | is_get | is_exist) & found;
         // only a get hit returns data
         rsp_data_in  = (is_get & found) ? READ_WIDTH'(sel_value) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff  <= rsp_hit_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tdata  = rsp_data_ff;

   // live entries always form a prefix of the row
   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      ((valid_vec >> 1) & ~valid_vec) == '0)
      else $error("valid cells do not form a prefix");

   // a key is held by at most one live cell
   a_unique_key: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("key matches more than one cell");

   // after a put the front cell is live unless capacity is zero
   a_put_front: assert property (@(posedge clock) disable iff (reset)
      accept && is_put |=> valid_vec[0] == ($past(csr_capacity_ff) != '0))
      else $error("front cell state wrong after put");

   // a miss never carries data
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("miss result carries nonzero data");

endmodule

`default_nettype wire

>>> test/lru_key_value_cache_checker.sv
// checker for the lru key/value cache: predicts every result and compares it
`timescale 1ns / 1ps

module lru_key_value_cache_checker #(
   parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF,
   parameter int KEY_WIDTH   = lkvc_pkg::KEY_WIDTH_DEF,
   parameter int VALUE_WIDTH = lkvc_pkg::VALUE_WIDTH_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_tvalid,
   input  logic                                       req_tready,
   // key, value, zero pad
   input  logic [((KEY_WIDTH+VALUE_WIDTH+7)/8)*8-1:0] req_tdata,
   // cmd
   input  logic [1:0]                                 req_tuser,
   input  logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   // read_value
   input  logic [lkvc_pkg::READ_WIDTH-1:0]            rsp_tdata,
   // hit
   input  logic                                       rsp_tuser,
   input  logic                                       csr_wr_en,
   input  logic [lkvc_pkg::CAPACITY_WIDTH-1:0]        csr_wr_data,
   output int                                         failures,
   output int                                         outstanding,
   output int                                         checked,
   output int                                         hits
);

   import lkvc_pkg::*;

   typedef struct {
      logic                  hit;
      logic [READ_WIDTH-1:0] read_value;
   } lookup_result_type;

   // model of the cache contents, slot 0 most recent
   logic [KEY_WIDTH-1:0]      ent_key [MAX_ENTRIES];
   logic [VALUE_WIDTH-1:0]    ent_val [MAX_ENTRIES];
   int unsigned               live;
   logic [CAPACITY_WIDTH-1:0] capacity;

   lookup_result_type pending_results[$];
   int fail_n    = 0;
   int checked_n = 0;
   int hits_n    = 0;

   function automatic int unsigned find_slot(input logic [KEY_WIDTH-1:0] k);
      for (int unsigned i = 0; i < live; i++)
         if (ent_key[i] == k)
            return i;
      return MAX_ENTRIES;
   endfunction

   task automatic bring_front(input int unsigned p);
      logic [KEY_WIDTH-1:0]   k;
      logic [VALUE_WIDTH-1:0] v;
      k = ent_key[p];
      v = ent_val[p];
      for (int unsigned i = p; i > 0; i--) begin
         ent_key[i] = ent_key[i-1];
         ent_val[i] = ent_val[i-1];
      end
      ent_key[0] = k;
      ent_val[0] = v;
   endtask

   task automatic lookup_and_update(input logic [1:0] cmd,
                                    input logic [KEY_WIDTH-1:0] k,
                                    input logic [VALUE_WIDTH-1:0] v,
                                    output lookup_result_type res);
      int unsigned pos;
      int unsigned lim;
      pos = find_slot(k);
      res.hit = 1'b0;
      res.read_value = '0;
      case (cmd)
         CMD_PUT: begin
            res.hit = (pos < MAX_ENTRIES);
            if (pos < MAX_ENTRIES) begin
               bring_front(pos);
            end else begin
               // a full row pushes out its least recent entry
               if (live < MAX_ENTRIES)
                  live++;
               bring_front(live - 1);
            end
            ent_key[0] = k;
            ent_val[0] = v;
            lim = (capacity > MAX_ENTRIES) ? MAX_ENTRIES : capacity;
            if (live > lim)
               live = lim;
         end
         CMD_GET: begin
            if (pos < MAX_ENTRIES) begin
               bring_front(pos);
               res.hit = 1'b1;
               res.read_value = READ_WIDTH'(ent_val[0]);
            end
         end
         CMD_EXIST: begin
            res.hit = (pos < MAX_ENTRIES);
         end
         default: ;   // spare code does nothing
      endcase
   endtask

   always @(posedge clock) begin
      lookup_result_type exp_res;
      lookup_result_type new_res;
      if (reset) begin
         live = 0;
         capacity = CAPACITY_RESET;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            ent_key[i] = '0;
            ent_val[i] = '0;
         end
         pending_results.delete();
      end else begin
         if (csr_wr_en)
            capacity = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               fail_n++;
               $display("%0t: result with nothing pending, actual hit %0b value %h",
                        $time, rsp_tuser, rsp_tdata);
            end else begin
               exp_res = pending_results.pop_front();
               checked_n++;
               if (rsp_tuser)
                  hits_n++;
               if (rsp_tuser !== exp_res.hit) begin
                  fail_n++;
                  $display("%0t: hit mismatch, expected %0b actual %0b",
                           $time, exp_res.hit, rsp_tuser);
               end
               if (rsp_tdata !== exp_res.read_value) begin
                  fail_n++;
                  $display("%0t: read_value mismatch, expected %h actual %h",
                           $time, exp_res.read_value, rsp_tdata);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            lookup_and_update(req_tuser, req_tdata[KEY_WIDTH-1:0],
                              req_tdata[KEY_WIDTH+VALUE_WIDTH-1:KEY_WIDTH], new_res);
            pending_results.insert(pending_results.size(), new_res);
         end
      end
      failures    <= fail_n;
      outstanding <= pending_results.size();
      checked     <= checked_n;
      hits        <= hits_n;
   end

endmodule

>>> test/lru_key_value_cache_core_tb.sv
// testbench top for the lru key/value cache: stimulus, flow control and verdict
`timescale 1ns / 1ps

module lru_key_value_cache_core_tb;
   import lkvc_pkg::*;

   localparam int REQ_W      = ((KEY_WIDTH_DEF + VALUE_WIDTH_DEF + 7) / 8) * 8;
   localparam int CYCLE_CAP  = 500000;   // far above the slowest legal run
   localparam int PHASES     = 10;
   localparam int PHASE_LEN  = 103;
   // the two-bit command field has one code the block leaves unused
   localparam logic [1:0] CMD_SPARE = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_tvalid  = 1'b0;
   logic                      req_tready;
   logic [REQ_W-1:0]          req_tdata   = '0;   // key, value
   logic [1:0]                req_tuser   = '0;   // cmd
   logic                      rsp_tvalid;
   logic                      rsp_tready  = 1'b0;
   logic [READ_WIDTH-1:0]     rsp_tdata;          // read_value
   logic                      rsp_tuser;          // hit
   logic                      csr_wr_en   = 1'b0;
   logic [CAPACITY_WIDTH-1:0] csr_wr_data = '0;

   int failures;
   int outstanding;
   int checked;
   int hits;

   int cycle_count = 0;
   int items_sent  = 0;
   int cfg_writes  = 0;
   int idle_mode   = 1;   // 0: no gaps on either side, 1: random gaps from draw_gap
   int rsp_hold    = 0;

   // keys of the current phase, drawn fresh so hits and updates are frequent
   logic [31:0] key_pool [32];
   int          pool_n = 1;

   lru_key_value_cache_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   lru_key_value_cache_checker chk (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .failures    (failures),
      .outstanding (outstanding),
      .checked     (checked),
      .hits        (hits)
   );

   // 20 ns clock
   initial begin
      forever #10 clock = ~clock;
   end

   // run guard, covers a hung handshake or a result that never comes
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_CAP) begin
         $display("timeout after %0d cycles, %0d results still pending",
                  cycle_count, outstanding);
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic int draw_gap();
      return (idle_mode == 0) ? 0 : $urandom_range(0, 18);
   endfunction

   // receiver: after each accepted item, hold tready low for a drawn number of cycles
   always @(posedge clock) begin
      int n;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= 0;
      end else if (rsp_tready && rsp_tvalid) begin
         n = draw_gap();
         if (n > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold   <= n - 1;
         end
      end else if (!rsp_tready) begin
         if (rsp_hold == 0)
            rsp_tready <= 1'b1;
         else
            rsp_hold <= rsp_hold - 1;
      end
   end

   // present one item after a drawn gap and wait for the handshake
   task automatic send_item(input logic [1:0] cmd, input logic [31:0] k,
                            input logic [31:0] v);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {v, k};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // stop sending and wait until every predicted result has been taken,
   // then let the clock run on before returning
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAPACITY_WIDTH-1:0] c);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= c;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cfg_writes++;
   endtask

   function automatic logic [1:0] pick_cmd();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40)
         return CMD_PUT;
      else if (r < 75)
         return CMD_GET;
      else if (r < 95)
         return CMD_EXIST;
      return CMD_SPARE;
   endfunction

   // mostly keys of the pool, some fully random ones that nearly always miss
   function automatic logic [31:0] pick_key();
      if ($urandom_range(0, 99) < 85)
         return key_pool[$urandom_range(0, pool_n - 1)];
      return $urandom;
   endfunction

   function automatic logic [31:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return 32'h0000_0000;
      else if (r == 1)
         return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   task automatic fill_pool();
      pool_n = $urandom_range(2, 24);
      for (int i = 0; i < pool_n; i++)
         key_pool[i] = $urandom;
      // extreme keys show up in some pools
      if ($urandom_range(0, 1) == 1)
         key_pool[0] = 32'h8000_0000;
      if ($urandom_range(0, 1) == 1)
         key_pool[pool_n - 1] = 32'h7FFF_FFFF;
   endtask

   initial begin
      logic [CAPACITY_WIDTH-1:0] phase_cap [PHASES];
      phase_cap = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd3, 5'd8, 5'd17, 5'd15, 5'd2, 5'd16};
      phase_cap[PHASES-1] = CAPACITY_WIDTH'($urandom_range(0, 31));

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, capacity still at its reset value
      send_item(CMD_GET,   32'h0000_0000, 32'hDEAD_BEEF);   // miss on an empty cache
      send_item(CMD_EXIST, 32'h8000_0000, 32'h0000_0000);
      send_item(CMD_SPARE, $urandom,      $urandom);
      send_item(CMD_PUT,   32'h8000_0000, 32'hFFFF_FFFF);
      send_item(CMD_PUT,   32'h7FFF_FFFF, 32'h0000_0000);
      send_item(CMD_PUT,   32'h0000_0000, 32'h5A5A_5A5A);
      send_item(CMD_PUT,   32'hFFFF_FFFF, 32'h1234_5678);
      send_item(CMD_GET,   32'h8000_0000, 32'h0000_0000);   // hit, moves to front
      send_item(CMD_EXIST, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_item(CMD_PUT,   32'h7FFF_FFFF, 32'hFFFF_FFFF);   // update of a present key
      send_item(CMD_GET,   32'h7FFF_FFFF, 32'h0000_0000);
      send_item(CMD_GET,   32'h0000_0001, 32'h0000_0000);   // get miss with entries present
      send_item(CMD_SPARE, 32'h8000_0000, 32'hFFFF_FFFF);   // spare code on a present key

      // lowering capacity leaves entries in place until the next put
      write_capacity(5'd1);
      send_item(CMD_EXIST, 32'h0000_0000, 32'h0000_0000);
      send_item(CMD_EXIST, 32'hFFFF_FFFF, 32'h0000_0000);
      send_item(CMD_PUT,   32'hA5A5_A5A5, 32'h0000_0001);
      send_item(CMD_EXIST, 32'h7FFF_FFFF, 32'h0000_0000);
      send_item(CMD_GET,   32'hA5A5_A5A5, 32'h0000_0000);

      // capacity zero: put reports prior presence but keeps nothing
      write_capacity(5'd0);
      send_item(CMD_PUT,   32'hA5A5_A5A5, 32'h0000_0002);
      send_item(CMD_EXIST, 32'hA5A5_A5A5, 32'h0000_0000);
      send_item(CMD_PUT,   32'h0000_0005, 32'hFFFF_FFFF);

      // capacity above the slot count behaves as a full row
      write_capacity(5'd31);
      send_item(CMD_PUT,   32'h8000_0000, 32'h0000_0003);
      send_item(CMD_GET,   32'h8000_0000, 32'h0000_0000);
      send_item(CMD_EXIST, 32'h0000_0000, 32'h0000_0000);

      // random phases, one capacity each, some without any idling
      for (int p = 0; p < PHASES; p++) begin
         write_capacity(phase_cap[p]);
         idle_mode = (p % 4 == 2) ? 0 : 1;
         fill_pool();
         for (int i = 0; i < PHASE_LEN; i++) begin
            // now and then the sender waits for the block to run empty
            if (p % 3 == 1 && i == PHASE_LEN / 2)
               settle();
            send_item(pick_cmd(), pick_key(), pick_value());
         end
      end

      settle();
      repeat (10) @(posedge clock);

      $display("sent %0d items under %0d capacity writes, including 0, 1 and 31",
               items_sent, cfg_writes);
      $display("checked %0d results, %0d of them hits", checked, hits);
      if (failures == 0 && outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", failures);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
